// ===== rtl/coherence_directory_table_macros.svh =====
// Assertion macros for the coherence directory table checker.
// Depends on nothing; included by the checker file.
`ifndef COHERENCE_DIRECTORY_TABLE_MACROS_SVH
`define COHERENCE_DIRECTORY_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("coherence directory table assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coherence directory table assertion failed");

`endif

// ===== rtl/cdt_pkg.sv =====
// Shared types and constants for the coherence directory table.
// Depends on nothing; used by the top level, its checker and the testbench.
package cdt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_CORES     = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 64;
  localparam int STATE_W = 2;
  localparam int REQ_W   = 7;
  localparam int MASK_W  = 64;
  localparam int CORES_W = 7;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATE_W-1:0] ST_UNCACHED  = 2'd0;
  localparam logic [STATE_W-1:0] ST_SHARED    = 2'd1;
  localparam logic [STATE_W-1:0] ST_EXCLUSIVE = 2'd2;
  localparam logic [STATE_W-1:0] ST_MODIFIED  = 2'd3;

  localparam logic [CORES_W-1:0] ACTIVE_CORES_RST = 7'd4;
  localparam logic [CFG_AW-3:0]  REG_ACTIVE_CORES = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0]  tag;
    logic [STATE_W-1:0] coh;
    logic [MASK_W-1:0]  sharers;
  } cdt_entry_t;

endpackage

// ===== rtl/coherence_directory_table.sv =====
// Top level of the coherence directory table: tag scan, entry update, config port.
// Depends on cdt_pkg.
//
// channel   direction  handshake             payload
// input     in         start / busy          in_operation, in_line_address,
//                                            in_new_state, in_requester
// result    out        out_valid (strobe)    out_present, out_entry_state,
//                                            out_sharer_mask, out_table_full
// config    cfg        psel/penable/pready   paddr, pwdata, prdata
//
// One transaction at a time; busy is high from acceptance until the result strobe.
// The entry memory, with one write port and one read port, is scanned one entry per
// cycle; a hit ends the scan early and a miss scans all entries. The S_UPDATE state
// writes back a changed entry. Synchronous active-low reset clears all valid bits
// at once. The receiver cannot stall; each result shows for one cycle.
module coherence_directory_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cdt_pkg::OP_W-1:0]      in_operation,
  input  logic [cdt_pkg::ADDR_W-1:0]    in_line_address,
  input  logic [cdt_pkg::STATE_W-1:0]   in_new_state,
  input  logic signed [cdt_pkg::REQ_W-1:0] in_requester,
  output logic                          out_valid,
  output logic                          out_present,
  output logic [cdt_pkg::STATE_W-1:0]   out_entry_state,
  output logic [cdt_pkg::MASK_W-1:0]    out_sharer_mask,
  output logic                          out_table_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdt_pkg::CFG_AW-1:0]    paddr,
  input  logic [cdt_pkg::CFG_DW-1:0]    pwdata,
  output logic [cdt_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import cdt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} fsm_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CORES_W-1:0] MAX_CORES_C = CORES_W'(MAX_CORES);

  fsm_t                 state_r;
  logic [CORES_W-1:0]   active_cores_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [OP_W-1:0]      req_op_r;
  logic [ADDR_W-1:0]    req_addr_r;
  logic [STATE_W-1:0]   req_state_r;
  logic [MASK_W-1:0]    req_bit_r;

  logic [IDX_W-1:0]     idx_r;
  logic                 issuing_r;
  logic                 chk_vld_r;
  logic [IDX_W-1:0]     chk_idx_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [STATE_W-1:0]   hit_coh_r;
  logic [MASK_W-1:0]    hit_sh_r;
  logic                 free_found_r;
  logic [IDX_W-1:0]     free_idx_r;

  logic                 out_valid_r;
  logic                 out_present_r;
  logic [STATE_W-1:0]   out_entry_state_r;
  logic [MASK_W-1:0]    out_sharer_mask_r;
  logic                 out_table_full_r;

  cdt_entry_t           mem [TABLE_ENTRIES];
  cdt_entry_t           rd_data_r;
  cdt_entry_t           wr_data;
  logic [IDX_W-1:0]     wr_idx;
  logic                 mem_we;

  logic                 cfg_wr;
  logic                 chk_match;
  logic [MASK_W-1:0]    req_bit;
  logic [CORES_W-1:0]   core_limit;

  logic                 upd_present;
  logic [STATE_W-1:0]   upd_coh;
  logic [MASK_W-1:0]    upd_sh;
  logic                 upd_full;
  logic                 upd_clr;
  logic                 upd_set;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_AW-1:2] == REG_ACTIVE_CORES) ?
                  CFG_DW'(active_cores_r) : '0;

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_present     = out_present_r;
  assign out_entry_state = out_entry_state_r;
  assign out_sharer_mask = out_sharer_mask_r;
  assign out_table_full  = out_table_full_r;

  assign core_limit = (active_cores_r < MAX_CORES_C) ? active_cores_r : MAX_CORES_C;
  always_comb begin
    req_bit = '0;
    if (!in_requester[REQ_W-1] && (CORES_W'(in_requester) < core_limit)) begin
      req_bit = MASK_W'(1) << in_requester[REQ_W-2:0];
    end
  end

  assign chk_match = valid_r[chk_idx_r] && (rd_data_r.tag == req_addr_r);

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    upd_present = 1'b0;
    upd_coh     = ST_UNCACHED;
    upd_sh      = '0;
    upd_full    = 1'b0;
    upd_clr     = 1'b0;
    upd_set     = 1'b0;
    mem_we      = 1'b0;
    wr_idx      = hit_idx_r;
    if (hit_r) begin
      upd_present = 1'b1;
      upd_coh     = hit_coh_r;
      upd_sh      = hit_sh_r;
      if (req_op_r == OP_UPDATE) begin
        case (req_state_r)
          ST_UNCACHED: begin
            upd_clr     = 1'b1;
            upd_present = 1'b0;
            upd_coh     = ST_UNCACHED;
            upd_sh      = '0;
          end
          ST_SHARED: begin
            upd_coh = ST_SHARED;
            upd_sh  = hit_sh_r | req_bit_r;
            mem_we  = 1'b1;
          end
          default: begin
            upd_coh = req_state_r;
            upd_sh  = req_bit_r;
            mem_we  = 1'b1;
          end
        endcase
      end
    end else if (req_op_r == OP_LOOKUP || req_op_r == OP_UPDATE) begin
      if (free_found_r) begin
        upd_present = 1'b1;
        upd_set     = 1'b1;
        mem_we      = 1'b1;
        wr_idx      = free_idx_r;
        if (req_op_r == OP_UPDATE) begin
          upd_coh = req_state_r;
          upd_sh  = req_bit_r;
        end
      end else begin
        upd_full = 1'b1;
      end
    end
    if (state_r != S_UPDATE) begin
      mem_we  = 1'b0;
      upd_clr = 1'b0;
      upd_set = 1'b0;
    end
    wr_data = '{tag: req_addr_r, coh: upd_coh, sharers: upd_sh};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      active_cores_r <= ACTIVE_CORES_RST;
      valid_r        <= '0;
      issuing_r      <= 1'b0;
      chk_vld_r      <= 1'b0;
      hit_r          <= 1'b0;
      free_found_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      idx_r          <= '0;
    end else begin
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      if (cfg_wr && paddr[CFG_AW-1:2] == REG_ACTIVE_CORES) begin
        active_cores_r <= pwdata[CORES_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_op_r     <= in_operation;
            req_addr_r   <= in_line_address;
            req_state_r  <= in_new_state;
            req_bit_r    <= req_bit;
            idx_r        <= '0;
            issuing_r    <= 1'b1;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld_r <= issuing_r;
          chk_idx_r <= idx_r;
          if (issuing_r) begin
            if (idx_r == LAST_IDX) begin
              issuing_r <= 1'b0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
          if (chk_vld_r) begin
            if (chk_match) begin
              hit_r     <= 1'b1;
              hit_idx_r <= chk_idx_r;
              hit_coh_r <= rd_data_r.coh;
              hit_sh_r  <= rd_data_r.sharers;
              issuing_r <= 1'b0;
              state_r   <= S_UPDATE;
            end else begin
              if (!valid_r[chk_idx_r] && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= chk_idx_r;
              end
              if (chk_idx_r == LAST_IDX) begin
                state_r <= S_UPDATE;
              end
            end
          end
        end
        S_UPDATE: begin
          out_valid_r       <= 1'b1;
          out_present_r     <= upd_present;
          out_entry_state_r <= upd_coh;
          out_sharer_mask_r <= upd_sh;
          out_table_full_r  <= upd_full;
          if (upd_clr) begin
            valid_r[hit_idx_r] <= 1'b0;
          end
          if (upd_set) begin
            valid_r[free_idx_r] <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cdt_checker.sv =====
// Port-level checker for the coherence directory table, bound to the top level.
// Depends on cdt_pkg and coherence_directory_table_macros.svh.
`include "coherence_directory_table_macros.svh"

module cdt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_present,
  input logic [cdt_pkg::STATE_W-1:0]   out_entry_state,
  input logic [cdt_pkg::MASK_W-1:0]    out_sharer_mask,
  input logic                          out_table_full
);
  import cdt_pkg::*;

  `CDT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `CDT_ASSERT_IMP(a_result_after_busy, clk, rst_n, out_valid, $past(busy))
  `CDT_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `CDT_ASSERT_IMP(a_absent_zero, clk, rst_n, out_valid && !out_present,
                  out_entry_state == ST_UNCACHED && out_sharer_mask == '0)
  `CDT_ASSERT_IMP(a_full_absent, clk, rst_n, out_valid && out_table_full, !out_present)

endmodule

bind coherence_directory_table cdt_checker u_cdt_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for coherence_directory_table: directed table, table fill, then random phases.
// Depends on cdt_pkg and the coherence_directory_table RTL; a local model predicts each reply not typed in a row.
module testbench;
  import cdt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int POOL_SIZE     = 96;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int FILL_ITEMS    = 70;
  localparam int DIRECTED_MAX  = 32;
  localparam int REPLY_DEPTH   = 16;

  localparam logic [OP_W-1:0]  OP_UNKNOWN   = 2'd3;
  localparam logic [REQ_W-1:0] REQ_NONE     = 7'h7f;
  localparam logic [REQ_W-1:0] REQ_MOST_NEG = 7'h40;
  localparam logic [MASK_W-1:0] CORE63_BIT  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               present;
    logic [STATE_W-1:0] state;
    logic [MASK_W-1:0]  mask;
    logic               full;
  } dir_reply_t;

  typedef struct packed {
    logic [CORES_W-1:0] cores;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [STATE_W-1:0] st;
    logic [REQ_W-1:0]   req;
    logic               typed;
    dir_reply_t         reply;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  logic [ADDR_W-1:0]   in_line_address;
  logic [STATE_W-1:0]  in_new_state;
  logic [REQ_W-1:0]    in_requester;
  logic                out_valid;
  logic                out_present;
  logic [STATE_W-1:0]  out_entry_state;
  logic [MASK_W-1:0]   out_sharer_mask;
  logic                out_table_full;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  coherence_directory_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_line_address (in_line_address),
    .in_new_state    (in_new_state),
    .in_requester    (in_requester),
    .out_valid       (out_valid),
    .out_present     (out_present),
    .out_entry_state (out_entry_state),
    .out_sharer_mask (out_sharer_mask),
    .out_table_full  (out_table_full),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // directory model state
  logic                model_valid   [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   model_tag     [TABLE_ENTRIES];
  logic [STATE_W-1:0]  model_coh     [TABLE_ENTRIES];
  logic [MASK_W-1:0]   model_sharers [TABLE_ENTRIES];
  logic [CORES_W-1:0]  model_cores;

  dir_reply_t          expected_replies [REPLY_DEPTH];
  int                  reply_wr;
  int                  reply_rd;
  dir_row_t            directed_rows [DIRECTED_MAX];
  int                  row_count;
  logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
  int                  error_count;
  int                  cycle_count;
  int                  burst_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("coherence_directory_table test failed");
      $finish;
    end
  end

  function automatic int claim_slot(logic [ADDR_W-1:0] addr, logic [STATE_W-1:0] st,
                                    logic [MASK_W-1:0] mask);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!model_valid[i]) begin
        model_valid[i]   = 1'b1;
        model_tag[i]     = addr;
        model_coh[i]     = st;
        model_sharers[i] = mask;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic dir_reply_t predict_directory(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                                   logic [STATE_W-1:0] st, logic [REQ_W-1:0] req);
    dir_reply_t       r;
    logic [MASK_W-1:0] core_sel;
    int               limit;
    int               slot;
    r = '0;
    core_sel = '0;
    limit = (int'(model_cores) < MAX_CORES) ? int'(model_cores) : MAX_CORES;
    if (!req[REQ_W-1] && int'(req) < limit) core_sel = 64'd1 << req[5:0];
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && model_valid[i] && model_tag[i] == addr) slot = i;
    end
    if (op == OP_LOOKUP) begin
      if (slot < 0) begin
        slot = claim_slot(addr, ST_UNCACHED, '0);
        r.full = (slot < 0);
      end
    end else if (op == OP_UPDATE) begin
      if (slot < 0) begin
        slot = claim_slot(addr, st, core_sel);
        r.full = (slot < 0);
      end else if (st == ST_UNCACHED) begin
        model_valid[slot] = 1'b0;
        slot = -1;
      end else if (st == ST_SHARED) begin
        model_coh[slot] = ST_SHARED;
        model_sharers[slot] = model_sharers[slot] | core_sel;
      end else begin
        model_coh[slot] = st;
        model_sharers[slot] = core_sel;
      end
    end
    if (slot >= 0) begin
      r.present = 1'b1;
      r.state   = model_coh[slot];
      r.mask    = model_sharers[slot];
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [CORES_W-1:0] cores, logic [OP_W-1:0] op,
      logic [ADDR_W-1:0] addr, logic [STATE_W-1:0] st, logic [REQ_W-1:0] req, logic typed,
      logic present, logic [STATE_W-1:0] state, logic [MASK_W-1:0] mask, logic full);
    dir_row_t row;
    row.cores = cores;
    row.op = op;
    row.addr = addr;
    row.st = st;
    row.req = req;
    row.typed = typed;
    row.reply.present = present;
    row.reply.state = state;
    row.reply.mask = mask;
    row.reply.full = full;
    return row;
  endfunction

  task automatic add_row(input dir_row_t row);
    directed_rows[row_count] = row;
    row_count++;
  endtask

  // hold start high until the block takes the transaction
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
      input logic [STATE_W-1:0] st, input logic [REQ_W-1:0] req,
      input logic typed, input dir_reply_t typed_reply);
    int         gap;
    dir_reply_t predicted;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      start           <= 1'b0;
      in_operation    <= OP_W'($urandom);
      in_line_address <= {$urandom, $urandom};
      in_new_state    <= STATE_W'($urandom);
      in_requester    <= REQ_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_line_address <= addr;
    in_new_state    <= st;
    in_requester    <= req;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_directory(op, addr, st, req);
    expected_replies[reply_wr % REPLY_DEPTH] = typed ? typed_reply : predicted;
    reply_wr++;
  endtask

  task automatic idle_inputs();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_cores(input logic [CORES_W-1:0] value);
    logic [CFG_DW-1:0] noise;
    noise = $urandom;
    idle_inputs();
    while (reply_wr != reply_rd || busy !== 1'b0) @(posedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_CORES, 2'b00};
    pwdata  <= {noise[CFG_DW-1:CORES_W], value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model_cores = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[CORES_W-1:0] !== value) begin
      $display("%0t: active_cores readback mismatch, expected %0d, actual %0d",
               $time, value, prdata[CORES_W-1:0]);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [CORES_W-1:0] cores, input int count, input int span);
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [STATE_W-1:0] st;
    logic [REQ_W-1:0]   req;
    int                 roll;
    int                 limit;
    bit                 stray;
    write_cores(cores);
    limit = (int'(model_cores) < MAX_CORES) ? int'(model_cores) : MAX_CORES;
    for (int n = 0; n < count; n++) begin
      stray = ($urandom_range(0, 99) < 8);
      addr = stray ? {$urandom, $urandom} : addr_pool[$urandom_range(0, span - 1)];
      roll = $urandom_range(0, 99);
      if (stray) begin
        op = (roll < 85) ? OP_READ : (roll < 90) ? OP_UNKNOWN : (roll < 95) ? OP_UPDATE
           : OP_LOOKUP;
      end else begin
        op = (roll < 30) ? OP_LOOKUP : (roll < 75) ? OP_UPDATE : (roll < 95) ? OP_READ
           : OP_UNKNOWN;
      end
      st = ($urandom_range(0, 9) < 4) ? ST_SHARED : STATE_W'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      if (roll < 7 && limit > 0) req = REQ_W'($urandom_range(0, limit - 1));
      else if (roll < 8) req = REQ_NONE;
      else req = REQ_W'($urandom);
      issue_request(op, addr, st, req, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    dir_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (reply_wr == reply_rd) begin
        $display("%0t: unexpected reply present=%0b state=%0d mask=%h full=%0b", $time,
                 out_present, out_entry_state, out_sharer_mask, out_table_full);
        error_count++;
      end else begin
        want = expected_replies[reply_rd % REPLY_DEPTH];
        reply_rd++;
        if (out_present !== want.present || out_entry_state !== want.state ||
            out_sharer_mask !== want.mask || out_table_full !== want.full) begin
          $display("%0t: reply mismatch, expected present=%0b state=%0d mask=%h full=%0b",
                   $time, want.present, want.state, want.mask, want.full);
          $display("%0t:                   actual present=%0b state=%0d mask=%h full=%0b",
                   $time, out_present, out_entry_state, out_sharer_mask, out_table_full);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [CORES_W-1:0] phase_cores [PHASES];
    int                 phase_span  [PHASES];
    dir_row_t           row;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    reply_wr = 0;
    reply_rd = 0;
    row_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = '0;
    in_line_address = '0;
    in_new_state = '0;
    in_requester = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    model_cores = ACTIVE_CORES_RST;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      model_valid[i] = 1'b0;
      model_tag[i] = '0;
      model_coh[i] = ST_UNCACHED;
      model_sharers[i] = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = 64'h8000_0000_0000_0000;
    addr_pool[3] = 64'd1;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom};

    add_row(mk_row(4, OP_READ, '0, ST_UNCACHED, 0, 1, 0, ST_UNCACHED, 0, 0));
    add_row(mk_row(4, OP_LOOKUP, '0, ST_MODIFIED, 5, 1, 1, ST_UNCACHED, 0, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_SHARED, 3, 1, 1, ST_SHARED, 8, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_SHARED, 4, 1, 1, ST_SHARED, 8, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_SHARED, REQ_NONE, 1,
                   1, ST_SHARED, 8, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_SHARED, 0, 1, 1, ST_SHARED, 9, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_MODIFIED, 1, 1, 1, ST_MODIFIED, 2, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_EXCLUSIVE, REQ_NONE, 1,
                   1, ST_EXCLUSIVE, 0, 0));
    add_row(mk_row(4, OP_UPDATE, '0, ST_UNCACHED, 2, 1, 0, ST_UNCACHED, 0, 0));
    add_row(mk_row(4, OP_READ, '0, ST_SHARED, 1, 1, 0, ST_UNCACHED, 0, 0));
    add_row(mk_row(4, OP_UPDATE, '1, ST_MODIFIED, 0, 1, 1, ST_MODIFIED, 1, 0));
    add_row(mk_row(4, OP_UPDATE, 64'd5, ST_UNCACHED, 2, 1,
                   1, ST_UNCACHED, 4, 0));
    add_row(mk_row(4, OP_UNKNOWN, '1, ST_UNCACHED, 0, 1, 1, ST_MODIFIED, 1, 0));
    add_row(mk_row(4, OP_UPDATE, 64'h8000_0000_0000_0000, ST_SHARED,
                   REQ_MOST_NEG, 1, 1, ST_SHARED, 0, 0));
    add_row(mk_row(64, OP_UPDATE, 64'h8000_0000_0000_0000, ST_SHARED, 63, 1,
                   1, ST_SHARED, CORE63_BIT, 0));
    add_row(mk_row(64, OP_UPDATE, 64'd5, ST_EXCLUSIVE, 63, 1,
                   1, ST_EXCLUSIVE, CORE63_BIT, 0));
    add_row(mk_row(0, OP_UPDATE, '1, ST_SHARED, 0, 1, 1, ST_SHARED, 1, 0));
    add_row(mk_row(0, OP_LOOKUP, 64'h1234_5678_9abc_def0, ST_SHARED, 0, 0,
                   0, ST_UNCACHED, 0, 0));
    add_row(mk_row(127, OP_UPDATE, 64'h5555_5555_5555_5555, ST_MODIFIED, 63, 0,
                   0, ST_UNCACHED, 0, 0));
    add_row(mk_row(127, OP_READ, 64'haaaa_aaaa_aaaa_aaaa, ST_EXCLUSIVE, 7, 0,
                   0, ST_UNCACHED, 0, 0));
    add_row(mk_row(64, OP_UPDATE, '1, ST_MODIFIED, REQ_NONE, 1,
                   1, ST_MODIFIED, 0, 0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < row_count; i++) begin
      row = directed_rows[i];
      if (row.cores != model_cores) write_cores(row.cores);
      issue_request(row.op, row.addr, row.st, row.req, row.typed, row.reply);
    end

    // fill the table from the address pool, past the point where inserts are dropped
    for (int i = 0; i < FILL_ITEMS; i++) begin
      issue_request(($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_UPDATE, addr_pool[i],
                    STATE_W'($urandom_range(1, 3)), REQ_W'($urandom_range(0, 63)), 1'b0, '0);
    end

    phase_cores = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd63, 7'd37, 7'd4, 7'd64};
    phase_span  = '{POOL_SIZE, 8, 16, POOL_SIZE, 40, POOL_SIZE, 12, POOL_SIZE};
    for (int p = 0; p < PHASES; p++) begin
      run_phase((p == 5) ? CORES_W'($urandom_range(2, 62)) : phase_cores[p], PHASE_ITEMS,
                phase_span[p]);
    end

    idle_inputs();
    while (reply_wr != reply_rd) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("coherence_directory_table test passed");
    end else begin
      $display("coherence_directory_table test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cdt_pkg.sv
rtl/coherence_directory_table.sv
rtl/cdt_checker.sv
sim/testbench.sv
